FILE: design/ili_pkg.sv
`timescale 1ns / 1ps
package ili_pkg;

    localparam int unsigned DEPTH_DEF = 16;
    localparam int unsigned FUNC_W    = 2;
    localparam int unsigned POS_W     = 5;
    localparam int unsigned DATA_W    = 8;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned COUNT_W   = 5;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_READ   = 2'd2
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic             do_insert;
        logic             do_delete;
        logic [POS_W-1:0] pos;
    } t_cell_ctrl;

endpackage

FILE: design/indexed_list_insert_delete.sv
`timescale 1ns / 1ps
// A result is registered in the output register in the cycle after its item is accepted.
// Throughput: one item per cycle; every cell of the chain shifts in parallel, so the
// only limit is the output register being held by a stalled consumer.
// Reset (synchronous, active low) empties the list and drops any pending result;
// the entry cells themselves are not cleared.
module indexed_list_insert_delete
    import ili_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [POS_W-1:0]    i_pos,
    input  logic [DATA_W-1:0]   i_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [DATA_W-1:0]   o_value,
    output logic [COUNT_W-1:0]  o_count
);

    localparam int unsigned LW = $clog2(DEPTH + 1);
    localparam int unsigned CW = (LW > POS_W) ? LW : POS_W;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [DATA_W-1:0]   r_value;
    logic [COUNT_W-1:0]  r_count;
    logic [LW-1:0]       r_len;
    logic [LW-1:0]       n_len;

    logic                w_accept;
    t_status             w_status;
    logic [DATA_W-1:0]   w_value;
    logic [DATA_W-1:0]   w_read;
    logic [CW-1:0]       w_pos;
    logic [CW-1:0]       w_len;
    logic                w_ins_ok;
    logic                w_del_ok;
    t_cell_ctrl          w_ctrl;

    logic [DATA_W-1:0]   w_entry [DEPTH];
    logic [DATA_W-1:0]   w_tap   [DEPTH];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_pos      = CW'(i_pos);
    assign w_len      = CW'(r_len);

    always_comb begin
        w_read = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_read = w_read | w_tap[k];
        end
    end

    always_comb begin
        w_status = ST_OK;
        w_value  = '0;
        w_ins_ok = 1'b0;
        w_del_ok = 1'b0;
        n_len    = r_len;
        case (t_func'(i_func))
            FUNC_INSERT: begin
                if (w_pos > w_len) begin
                    w_status = ST_RANGE;
                end else if (w_len == CW'(DEPTH)) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins_ok = 1'b1;
                    n_len    = r_len + 1'b1;
                end
            end
            FUNC_DELETE, FUNC_READ: begin
                if (r_len == '0) begin
                    w_status = ST_EMPTY;
                end else if (w_pos >= w_len) begin
                    w_status = ST_RANGE;
                end else begin
                    w_value = w_read;
                    if (t_func'(i_func) == FUNC_DELETE) begin
                        w_del_ok = 1'b1;
                        n_len    = r_len - 1'b1;
                    end
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    assign w_ctrl.do_insert = w_accept && w_ins_ok;
    assign w_ctrl.do_delete = w_accept && w_del_ok;
    assign w_ctrl.pos       = i_pos;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;

        // chain ends feed back their own entry; the first cell's is never selected
        if (g == 0) begin : g_first
            assign w_left = w_entry[g];
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end

        ili_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_left  (w_left),
            .i_right (w_right),
            .i_data  (i_data),
            .o_entry (w_entry[g]),
            .o_tap   (w_tap[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_len       <= n_len;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= w_status;
            r_value  <= w_value;
            r_count  <= COUNT_W'(n_len);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_value     = r_value;
    assign o_count     = r_count;

endmodule

FILE: design/ili_cell.sv
`timescale 1ns / 1ps
module ili_cell
    import ili_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF,
    parameter int unsigned IDX   = 0
) (
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic [DATA_W-1:0] i_left,
    input  logic [DATA_W-1:0] i_right,
    input  logic [DATA_W-1:0] i_data,
    output logic [DATA_W-1:0] o_entry,
    output logic [DATA_W-1:0] o_tap
);

    localparam int unsigned IW = $clog2(DEPTH) + 1;
    localparam int unsigned CW = (IW > POS_W) ? IW : POS_W;

    logic [DATA_W-1:0] r_entry;
    logic [DATA_W-1:0] n_entry;
    logic [CW-1:0]     w_pos;
    logic [CW-1:0]     w_idx;

    assign w_pos = CW'(i_ctrl.pos);
    assign w_idx = CW'(IDX);

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.do_insert) begin
            if (w_idx > w_pos) begin
                n_entry = i_left;
            end else if (w_idx == w_pos) begin
                n_entry = i_data;
            end
        end else if (i_ctrl.do_delete) begin
            // close the gap: everything at or above pos takes its upper neighbor
            if (w_idx >= w_pos) begin
                n_entry = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_tap   = (w_idx == w_pos) ? r_entry : '0;

endmodule
